>>> src/rqns_pkg.sv
// Shared constants for the R-tree quadratic node split unit.
package rqns_pkg;

   // Default store depth and coordinate width
   localparam int MAX_ENTRIES_DEF = 16;
   localparam int COORD_BITS_DEF  = 16;

   // Fixed field widths of the register and result ports
   localparam int MIN_FILL_BITS = 4;
   localparam int IDX_BITS      = 4;

   // Reset value of the minimum group fill register
   localparam logic [MIN_FILL_BITS-1:0] MIN_FILL_RESET = 4'd6;

endpackage

>>> src/rqns_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rqns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/rqns_area_unit.sv
// Shared area unit: bounding box of two rectangles and its area, registered.
module rqns_area_unit #(
   parameter int COORD_BITS = rqns_pkg::COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic [4*COORD_BITS-1:0]   box_a,
   input  logic [4*COORD_BITS-1:0]   box_b,
   output logic [2*COORD_BITS-1:0]   area,
   output logic [4*COORD_BITS-1:0]   merged
);

   import rqns_pkg::*;

   localparam int CB = COORD_BITS;

   logic signed [CB-1:0] ax0, ay0, ax1, ay1;
   logic signed [CB-1:0] bx0, by0, bx1, by1;
   logic signed [CB-1:0] mx0, my0, mx1, my1;
   logic signed [CB:0]   dx, dy;
   logic [CB-1:0]        ext_x, ext_y;
   logic [2*CB-1:0]      area_ff;
   logic [4*CB-1:0]      merged_ff;

   // Split the packed boxes into corners
   assign ax0 = box_a[4*CB-1:3*CB];
   assign ay0 = box_a[3*CB-1:2*CB];
   assign ax1 = box_a[2*CB-1:CB];
   assign ay1 = box_a[CB-1:0];
   assign bx0 = box_b[4*CB-1:3*CB];
   assign by0 = box_b[3*CB-1:2*CB];
   assign bx1 = box_b[2*CB-1:CB];
   assign by1 = box_b[CB-1:0];

   // Common bounding box
   assign mx0 = (ax0 < bx0) ? ax0 : bx0;
   assign my0 = (ay0 < by0) ? ay0 : by0;
   assign mx1 = (ax1 > bx1) ? ax1 : bx1;
   assign my1 = (ay1 > by1) ? ay1 : by1;

   // Extents, zero on an inverted axis
   assign dx    = {mx1[CB-1], mx1} - {mx0[CB-1], mx0};
   assign dy    = {my1[CB-1], my1} - {my0[CB-1], my0};
   assign ext_x = (mx1 > mx0) ? dx[CB-1:0] : '0;
   assign ext_y = (my1 > my0) ? dy[CB-1:0] : '0;

   // One multiplier, product registered
   always_ff @(posedge clock) begin
      area_ff   <= ext_x * ext_y;
      merged_ff <= {mx0, my0, mx1, my1};
   end

   assign area   = area_ff;
   assign merged = merged_ff;

endmodule

>>> src/rtree_quadratic_node_split_unit.sv
// R-tree quadratic node split: rectangle store, seed pair search and group assignment.
// Load: a stored rectangle passes AREA and STORE, busy meanwhile; with the store full it is
// dropped and flagged. Split: a seed scan of all entry pairs through the single RAM read port
// and shared area multiplier, a drain, seed setup (INIT0-INIT2), ARD-AM0-AM1-ADEC per non-seed
// entry and ARD per seed, one result word per entry in index order; the receiver cannot stall.
// Synchronous active-high reset empties the store, clears flags and sets min_fill to 6.
module rtree_quadratic_node_split_unit #(
   parameter int MAX_ENTRIES = rqns_pkg::MAX_ENTRIES_DEF,
   parameter int COORD_BITS  = rqns_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [COORD_BITS-1:0]        req_rect_min_x,
   input  logic signed [COORD_BITS-1:0]        req_rect_min_y,
   input  logic signed [COORD_BITS-1:0]        req_rect_max_x,
   input  logic signed [COORD_BITS-1:0]        req_rect_max_y,
   input  logic                                req_last_entry,
   output logic                                rsp_valid,
   output logic [rqns_pkg::IDX_BITS-1:0]       rsp_entry_index,
   output logic                                rsp_group,
   output logic                                rsp_dropped_entries,
   output logic                                rsp_last_result,
   input  logic                                csr_wr_en,
   input  logic [rqns_pkg::MIN_FILL_BITS-1:0]  csr_wr_data
);

   import rqns_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int PW = 2 * CB;
   localparam int WW = PW + 2;
   localparam int BW = 4 * CB;
   localparam int RW = BW + PW;
   localparam int FW = (CW + 1 > MIN_FILL_BITS) ? CW + 1 : MIN_FILL_BITS;

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_AREA  = 12'b0000_0000_0010,
      ST_STORE = 12'b0000_0000_0100,
      ST_SEED  = 12'b0000_0000_1000,
      ST_DRAIN = 12'b0000_0001_0000,
      ST_INIT0 = 12'b0000_0010_0000,
      ST_INIT1 = 12'b0000_0100_0000,
      ST_INIT2 = 12'b0000_1000_0000,
      ST_ARD   = 12'b0001_0000_0000,
      ST_AM0   = 12'b0010_0000_0000,
      ST_AM1   = 12'b0100_0000_0000,
      ST_ADEC  = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // Control registers
   logic [CW-1:0]            entry_count_ff, entry_count_in;
   logic                     overflow_ff, overflow_in;
   logic [MIN_FILL_BITS-1:0] min_fill_ff, min_fill_in;
   logic [CW-1:0]            si_ff, si_in, sj_ff, sj_in;
   logic                     seed_load_ff, seed_load_in;
   logic                     first_ff, first_in;
   logic signed [WW-1:0]     best_ff, best_in;
   logic [CW-1:0]            bi_ff, bi_in, bj_ff, bj_in;
   logic [CW-1:0]            cnt0_ff, cnt0_in, cnt1_ff, cnt1_in;
   logic [CW-1:0]            rem_ff, rem_in;
   logic [CW-1:0]            ax_ff, ax_in;
   logic                     p1_valid_ff, p2_valid_ff, p3_valid_ff;
   logic                     rsp_valid_ff;

   // Payload registers
   logic [BW-1:0]            in_box_ff;
   logic                     last_ff;
   logic                     p1_load_ff;
   logic [CW-1:0]            p1_i_ff, p1_j_ff, p2_i_ff, p2_j_ff, p3_i_ff, p3_j_ff;
   logic [BW-1:0]            ri_ff;
   logic [PW-1:0]            ai_ff, p2_ai_ff, p2_aj_ff;
   logic signed [WW-1:0]     waste_ff;
   logic [BW-1:0]            gb0_ff, gb1_ff, rc_ff, mrg0_ff;
   logic [PW-1:0]            gba0_ff, gba1_ff, u0_ff, d0_ff;
   logic [IDX_BITS-1:0]      rsp_entry_index_ff;
   logic                     rsp_group_ff, rsp_dropped_ff, rsp_last_ff;

   // Combinational signals
   logic                     accept;
   logic                     store_full;
   logic [CW-1:0]            last_idx;
   logic                     issue_valid, issue_load;
   logic [CW-1:0]            rd_idx;
   logic                     ram_we;
   logic [RW-1:0]            ram_rd_data;
   logic [BW-1:0]            rd_box;
   logic [PW-1:0]            rd_area;
   logic [BW-1:0]            unit_a, unit_b, unit_merged;
   logic [PW-1:0]            unit_area;
   logic [PW-1:0]            d1;
   logic                     pick1, force_other, dec_grp;
   logic [FW-1:0]            need;
   logic                     emit_valid, emit_grp;
   logic                     is_seed0, is_seed1;

   assign accept     = start && !busy;
   assign busy       = (state_ff != ST_IDLE);
   assign store_full = (entry_count_ff == CW'(MAX_ENTRIES));
   assign last_idx   = entry_count_ff - CW'(1);
   assign rd_box     = ram_rd_data[RW-1:PW];
   assign rd_area    = ram_rd_data[PW-1:0];

   // Rectangle store: box and its area in one word
   rqns_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (entry_count_ff[AW-1:0]),
      .wr_data ({in_box_ff, unit_area}),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // Select the operands of the shared area unit
   always_comb begin
      unique case (state_ff)
         ST_AREA: begin
            unit_a = in_box_ff;
            unit_b = in_box_ff;
         end
         ST_AM0: begin
            unit_a = gb0_ff;
            unit_b = rd_box;
         end
         ST_AM1: begin
            unit_a = gb1_ff;
            unit_b = rc_ff;
         end
         default: begin
            unit_a = ri_ff;
            unit_b = rd_box;
         end
      endcase
   end

   rqns_area_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_area (
      .clock  (clock),
      .box_a  (unit_a),
      .box_b  (unit_b),
      .area   (unit_area),
      .merged (unit_merged)
   );

   // Group choice: least enlargement, ties to group 0, forced when the other group needs the rest
   assign d1          = unit_area - gba1_ff;
   assign pick1       = (d1 < d0_ff);
   assign need        = FW'(pick1 ? cnt0_ff : cnt1_ff) + FW'(rem_ff);
   assign force_other = (need <= FW'(min_fill_ff));
   assign dec_grp     = force_other ? !pick1 : pick1;
   assign is_seed0    = (ax_ff == bi_ff);
   assign is_seed1    = (ax_ff == bj_ff);

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      overflow_in    = overflow_ff;
      min_fill_in    = min_fill_ff;
      si_in          = si_ff;
      sj_in          = sj_ff;
      seed_load_in   = seed_load_ff;
      first_in       = first_ff;
      best_in        = best_ff;
      bi_in          = bi_ff;
      bj_in          = bj_ff;
      cnt0_in        = cnt0_ff;
      cnt1_in        = cnt1_ff;
      rem_in         = rem_ff;
      ax_in          = ax_ff;
      issue_valid    = 1'b0;
      issue_load     = 1'b0;
      rd_idx         = ax_ff;
      ram_we         = 1'b0;
      emit_valid     = 1'b0;
      emit_grp       = 1'b0;

      if (csr_wr_en) begin
         min_fill_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (store_full) begin
                  overflow_in = 1'b1;
                  if (req_last_entry) begin
                     si_in        = '0;
                     seed_load_in = 1'b1;
                     first_in     = 1'b1;
                     bi_in        = '0;
                     bj_in        = '0;
                     state_in     = ST_SEED;
                  end
               end else begin
                  state_in = ST_AREA;
               end
            end
         end
         ST_AREA: begin
            state_in = ST_STORE;
         end
         ST_STORE: begin
            ram_we         = 1'b1;
            entry_count_in = entry_count_ff + CW'(1);
            bi_in          = '0;
            bj_in          = '0;
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (entry_count_ff == '0) begin
               state_in = ST_INIT0;
            end else begin
               si_in        = '0;
               seed_load_in = 1'b1;
               first_in     = 1'b1;
               state_in     = ST_SEED;
            end
         end
         ST_SEED: begin
            // Issue one read a cycle: the outer entry, then each later partner
            issue_valid = 1'b1;
            if (seed_load_ff) begin
               issue_load   = 1'b1;
               rd_idx       = si_ff;
               seed_load_in = 1'b0;
               sj_in        = si_ff + CW'(1);
            end else begin
               rd_idx = sj_ff;
               if (sj_ff == last_idx) begin
                  if (si_ff + CW'(2) == entry_count_ff) begin
                     state_in = ST_DRAIN;
                  end else begin
                     si_in        = si_ff + CW'(1);
                     seed_load_in = 1'b1;
                  end
               end else begin
                  sj_in = sj_ff + CW'(1);
               end
            end
         end
         ST_DRAIN: begin
            if (!p1_valid_ff && !p2_valid_ff && !p3_valid_ff) begin
               state_in = ST_INIT0;
            end
         end
         ST_INIT0: begin
            rd_idx   = bi_ff;
            state_in = ST_INIT1;
         end
         ST_INIT1: begin
            rd_idx   = bj_ff;
            state_in = ST_INIT2;
         end
         ST_INIT2: begin
            cnt0_in  = CW'(1);
            cnt1_in  = CW'(1);
            rem_in   = entry_count_ff - CW'(2);
            ax_in    = '0;
            state_in = ST_ARD;
         end
         ST_ARD: begin
            rd_idx = ax_ff;
            if (is_seed0 || is_seed1) begin
               emit_valid = 1'b1;
               emit_grp   = !is_seed0;
               if (ax_ff == last_idx) begin
                  entry_count_in = '0;
                  overflow_in    = 1'b0;
                  state_in       = ST_IDLE;
               end else begin
                  ax_in = ax_ff + CW'(1);
               end
            end else begin
               state_in = ST_AM0;
            end
         end
         ST_AM0: begin
            state_in = ST_AM1;
         end
         ST_AM1: begin
            state_in = ST_ADEC;
         end
         ST_ADEC: begin
            emit_valid = 1'b1;
            emit_grp   = dec_grp;
            rem_in     = rem_ff - CW'(1);
            if (dec_grp) begin
               cnt1_in = cnt1_ff + CW'(1);
            end else begin
               cnt0_in = cnt0_ff + CW'(1);
            end
            if (ax_ff == last_idx) begin
               entry_count_in = '0;
               overflow_in    = 1'b0;
               state_in       = ST_IDLE;
            end else begin
               ax_in    = ax_ff + CW'(1);
               state_in = ST_ARD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Keep the pair of greatest waste, later pair on a tie
      if (p3_valid_ff && (first_ff || (waste_ff >= best_ff))) begin
         best_in  = waste_ff;
         bi_in    = p3_i_ff;
         bj_in    = p3_j_ff;
         first_in = 1'b0;
      end
   end

   // Control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         overflow_ff    <= 1'b0;
         min_fill_ff    <= MIN_FILL_RESET;
         si_ff          <= '0;
         sj_ff          <= '0;
         seed_load_ff   <= 1'b0;
         first_ff       <= 1'b0;
         best_ff        <= '0;
         bi_ff          <= '0;
         bj_ff          <= '0;
         cnt0_ff        <= '0;
         cnt1_ff        <= '0;
         rem_ff         <= '0;
         ax_ff          <= '0;
         p1_valid_ff    <= 1'b0;
         p2_valid_ff    <= 1'b0;
         p3_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         overflow_ff    <= overflow_in;
         min_fill_ff    <= min_fill_in;
         si_ff          <= si_in;
         sj_ff          <= sj_in;
         seed_load_ff   <= seed_load_in;
         first_ff       <= first_in;
         best_ff        <= best_in;
         bi_ff          <= bi_in;
         bj_ff          <= bj_in;
         cnt0_ff        <= cnt0_in;
         cnt1_ff        <= cnt1_in;
         rem_ff         <= rem_in;
         ax_ff          <= ax_in;
         p1_valid_ff    <= issue_valid;
         p2_valid_ff    <= p1_valid_ff && !p1_load_ff;
         p3_valid_ff    <= p2_valid_ff;
         rsp_valid_ff   <= emit_valid;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      // Hold the accepted rectangle
      if (accept) begin
         in_box_ff <= {req_rect_min_x, req_rect_min_y, req_rect_max_x, req_rect_max_y};
         last_ff   <= req_last_entry;
      end

      // Seed scan: tag, product, waste
      p1_load_ff <= issue_load;
      p1_i_ff    <= si_ff;
      p1_j_ff    <= rd_idx;
      if (p1_valid_ff && p1_load_ff) begin
         ri_ff <= rd_box;
         ai_ff <= rd_area;
      end
      p2_i_ff  <= p1_i_ff;
      p2_j_ff  <= p1_j_ff;
      p2_ai_ff <= ai_ff;
      p2_aj_ff <= rd_area;
      p3_i_ff  <= p2_i_ff;
      p3_j_ff  <= p2_j_ff;
      waste_ff <= $signed({2'b00, unit_area}) - $signed({2'b00, p2_ai_ff})
                  - $signed({2'b00, p2_aj_ff});

      // Seed boxes
      if (state_ff == ST_INIT1) begin
         gb0_ff  <= rd_box;
         gba0_ff <= rd_area;
      end
      if (state_ff == ST_INIT2) begin
         gb1_ff  <= rd_box;
         gba1_ff <= rd_area;
      end

      // Assignment of one entry
      if (state_ff == ST_AM0) begin
         rc_ff <= rd_box;
      end
      if (state_ff == ST_AM1) begin
         u0_ff   <= unit_area;
         d0_ff   <= unit_area - gba0_ff;
         mrg0_ff <= unit_merged;
      end
      if (state_ff == ST_ADEC) begin
         if (dec_grp) begin
            gb1_ff  <= unit_merged;
            gba1_ff <= unit_area;
         end else begin
            gb0_ff  <= mrg0_ff;
            gba0_ff <= u0_ff;
         end
      end

      // Result word
      rsp_entry_index_ff <= IDX_BITS'(ax_ff);
      rsp_group_ff       <= emit_grp;
      rsp_dropped_ff     <= overflow_ff;
      rsp_last_ff        <= (ax_ff == last_idx);
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_entry_index     = rsp_entry_index_ff;
   assign rsp_group           = rsp_group_ff;
   assign rsp_dropped_entries = rsp_dropped_ff;
   assign rsp_last_result     = rsp_valid_ff && rsp_last_ff;

endmodule

>>> src/rqns_checker.sv
// Port-level checks of the node split unit, bound to its top level.
module rqns_checker #(
   parameter int COORD_BITS = rqns_pkg::COORD_BITS_DEF
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic signed [COORD_BITS-1:0]        req_rect_min_x,
   input logic signed [COORD_BITS-1:0]        req_rect_min_y,
   input logic signed [COORD_BITS-1:0]        req_rect_max_x,
   input logic signed [COORD_BITS-1:0]        req_rect_max_y,
   input logic                                req_last_entry,
   input logic                                rsp_valid,
   input logic [rqns_pkg::IDX_BITS-1:0]       rsp_entry_index,
   input logic                                rsp_group,
   input logic                                rsp_dropped_entries,
   input logic                                rsp_last_result,
   input logic                                csr_wr_en,
   input logic [rqns_pkg::MIN_FILL_BITS-1:0]  csr_wr_data
);

   import rqns_pkg::*;

   // A final word starts a split, so the unit goes busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_entry) |=> busy)
      else $error("split not started after final word");

   // The last-result flag only travels with a result word
   assert property (@(posedge clock) disable iff (reset)
      rsp_last_result |-> rsp_valid)
      else $error("last result flag without result word");

   // The final result frees the unit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_result) |-> !busy)
      else $error("unit still busy after final result");

   // More results follow, so the unit stays busy
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_result) |-> busy)
      else $error("unit idle with results outstanding");

endmodule

bind rtree_quadratic_node_split_unit rqns_checker #(
   .COORD_BITS (COORD_BITS)
) u_rqns_checker (.*);
